@@ rtl/linked_list_free_pool_manager_defines.svh @@
// Assertion macros used by the checker file of the node pool manager.
`ifndef LINKED_LIST_FREE_POOL_MANAGER_DEFINES_SVH
`define LINKED_LIST_FREE_POOL_MANAGER_DEFINES_SVH

// Same-cycle implication, checked while reset is released.
`define LLFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("llfp check failed");

// Next-cycle implication, checked while reset is released.
`define LLFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("llfp check failed");

`endif

@@ rtl/llfp_pkg.sv @@
package llfp_pkg;

    // Default pool size; the null node index equals the pool size.
    localparam int NODES_DEF = 256;

    // Command codes.
    localparam logic [1:0] CMD_HEAD  = 2'd0;
    localparam logic [1:0] CMD_AFTER = 2'd1;
    localparam logic [1:0] CMD_DEL   = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    // Port enables of the two link memories.
    typedef struct packed {
        logic fwd_re;
        logic fwd_we;
        logic bwd_re;
        logic bwd_we;
    } t_mem_en;

endpackage

@@ rtl/llfp_link_mem.sv @@
module llfp_link_mem
    import llfp_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic                       i_clk,
    input  t_mem_en                    i_en,
    input  logic [$clog2(NODES)-1:0]   i_fwd_raddr,
    input  logic [$clog2(NODES)-1:0]   i_fwd_waddr,
    input  logic [$clog2(NODES+1):0]   i_fwd_wdata,
    output logic [$clog2(NODES+1):0]   o_fwd_rdata,
    input  logic [$clog2(NODES)-1:0]   i_bwd_raddr,
    input  logic [$clog2(NODES)-1:0]   i_bwd_waddr,
    input  logic [$clog2(NODES+1)-1:0] i_bwd_wdata,
    output logic [$clog2(NODES+1)-1:0] o_bwd_rdata
);

    localparam int NW = $clog2(NODES + 1);

    // Forward entry: in-list mark in the top bit, forward link below it.
    logic [NW:0]   r_fwd_mem [NODES];
    logic [NW-1:0] r_bwd_mem [NODES];
    logic [NW:0]   r_fwd_rdata;
    logic [NW-1:0] r_bwd_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en.fwd_we) begin
            r_fwd_mem[i_fwd_waddr] <= i_fwd_wdata;
        end
        if (i_en.fwd_re) begin
            r_fwd_rdata <= r_fwd_mem[i_fwd_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.bwd_we) begin
            r_bwd_mem[i_bwd_waddr] <= i_bwd_wdata;
        end
        if (i_en.bwd_re) begin
            r_bwd_rdata <= r_bwd_mem[i_bwd_raddr];
        end
    end

    assign o_fwd_rdata = r_fwd_rdata;
    assign o_bwd_rdata = r_bwd_rdata;

endmodule

@@ rtl/llfp_ctrl.sv @@
module llfp_ctrl
    import llfp_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_cmd,
    input  logic [$clog2(NODES+1)-1:0] i_node,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output logic [$clog2(NODES+1)-1:0] o_alloc,
    output logic [1:0]                 o_status,
    output logic [$clog2(NODES+1)-1:0] o_list_head,
    output logic [$clog2(NODES+1)-1:0] o_free_head,
    output t_mem_en                    o_en,
    output logic [$clog2(NODES)-1:0]   o_fwd_raddr,
    output logic [$clog2(NODES)-1:0]   o_fwd_waddr,
    output logic [$clog2(NODES+1):0]   o_fwd_wdata,
    input  logic [$clog2(NODES+1):0]   i_fwd_rdata,
    output logic [$clog2(NODES)-1:0]   o_bwd_raddr,
    output logic [$clog2(NODES)-1:0]   o_bwd_waddr,
    output logic [$clog2(NODES+1)-1:0] o_bwd_wdata,
    input  logic [$clog2(NODES+1)-1:0] i_bwd_rdata
);

    localparam int NW = $clog2(NODES + 1);
    localparam int AW = $clog2(NODES);
    localparam logic [NW-1:0] NIL  = NW'(NODES);
    localparam logic [AW-1:0] LAST = AW'(NODES - 1);

    typedef enum logic [13:0] {
        S_INIT = 14'h0001,
        S_IDLE = 14'h0002,
        S_H1   = 14'h0004,
        S_H2   = 14'h0008,
        S_H3   = 14'h0010,
        S_A1   = 14'h0020,
        S_A2   = 14'h0040,
        S_A3   = 14'h0080,
        S_A4   = 14'h0100,
        S_D1   = 14'h0200,
        S_D2   = 14'h0400,
        S_D3   = 14'h0800,
        S_D4   = 14'h1000,
        S_DONE = 14'h2000
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_init_cnt, n_init_cnt;
    logic [NW-1:0] r_used_head, n_used_head;
    logic [NW-1:0] r_pool_head, n_pool_head;
    logic [NW-1:0] r_node, n_node;
    logic [NW-1:0] r_f, n_f;
    logic [NW-1:0] r_nxt, n_nxt;
    logic [NW-1:0] r_prv, n_prv;
    logic [NW-1:0] r_alloc, n_alloc;
    logic [1:0]    r_status, n_status;

    logic          rd_mark;
    logic [NW-1:0] rd_fwd;
    logic [NW-1:0] rd_bwd;
    logic          in_fire;

    assign rd_mark = i_fwd_rdata[NW];
    assign rd_fwd  = i_fwd_rdata[NW-1:0];
    assign rd_bwd  = i_bwd_rdata;
    assign in_fire = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_init_cnt  = r_init_cnt;
        n_used_head = r_used_head;
        n_pool_head = r_pool_head;
        n_node      = r_node;
        n_f         = r_f;
        n_nxt       = r_nxt;
        n_prv       = r_prv;
        n_alloc     = r_alloc;
        n_status    = r_status;
        o_en        = '0;
        o_fwd_raddr = '0;
        o_fwd_waddr = '0;
        o_fwd_wdata = '0;
        o_bwd_raddr = '0;
        o_bwd_waddr = '0;
        o_bwd_wdata = '0;

        unique case (r_state)
            S_INIT: begin
                // Chain every node into the free list in index order.
                o_en.fwd_we = 1'b1;
                o_en.bwd_we = 1'b1;
                o_fwd_waddr = r_init_cnt;
                o_bwd_waddr = r_init_cnt;
                o_fwd_wdata = {1'b0, (r_init_cnt == LAST) ? NIL : NW'(r_init_cnt) + NW'(1)};
                o_bwd_wdata = (r_init_cnt == '0) ? NIL : NW'(r_init_cnt) - NW'(1);
                n_init_cnt  = r_init_cnt + AW'(1);
                if (r_init_cnt == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_node   = i_node;
                    n_f      = r_pool_head;
                    n_alloc  = NIL;
                    n_status = ST_OK;
                    n_state  = S_DONE;
                    unique case (i_cmd)
                        CMD_HEAD: begin
                            if (r_pool_head == NIL) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_state = S_H1;
                            end
                        end
                        CMD_AFTER: begin
                            if (i_node >= NIL) begin
                                n_status = ST_BAD;
                            end else if (r_pool_head == NIL) begin
                                n_status = ST_EMPTY;
                            end else if (r_used_head == NIL) begin
                                n_state = S_H1;
                            end else begin
                                n_state = S_A1;
                            end
                        end
                        CMD_DEL: begin
                            if (i_node >= NIL) begin
                                n_status = ST_BAD;
                            end else begin
                                n_state = S_D1;
                            end
                        end
                        default: begin
                            n_status = ST_BAD;
                        end
                    endcase
                end
            end
            S_H1: begin
                // Read the free successor while relinking the taken node.
                o_en.fwd_re = 1'b1;
                o_fwd_raddr = r_f[AW-1:0];
                o_en.fwd_we = 1'b1;
                o_fwd_waddr = r_f[AW-1:0];
                o_fwd_wdata = {1'b1, r_used_head};
                if (r_used_head != NIL) begin
                    o_en.bwd_we = 1'b1;
                    o_bwd_waddr = r_used_head[AW-1:0];
                    o_bwd_wdata = r_f;
                end
                n_state = S_H2;
            end
            S_H2: begin
                if (rd_fwd != NIL) begin
                    o_en.bwd_we = 1'b1;
                    o_bwd_waddr = rd_fwd[AW-1:0];
                    o_bwd_wdata = NIL;
                end
                n_pool_head = rd_fwd;
                n_used_head = r_f;
                n_alloc     = r_f;
                n_state     = S_H3;
            end
            S_H3: begin
                o_en.bwd_we = 1'b1;
                o_bwd_waddr = r_f[AW-1:0];
                o_bwd_wdata = NIL;
                n_state     = S_DONE;
            end
            S_A1: begin
                o_en.fwd_re = 1'b1;
                o_fwd_raddr = r_node[AW-1:0];
                n_state     = S_A2;
            end
            S_A2: begin
                if (!rd_mark) begin
                    n_status = ST_BAD;
                    n_state  = S_DONE;
                end else begin
                    n_nxt       = rd_fwd;
                    o_en.fwd_re = 1'b1;
                    o_fwd_raddr = r_f[AW-1:0];
                    o_en.fwd_we = 1'b1;
                    o_fwd_waddr = r_node[AW-1:0];
                    o_fwd_wdata = {1'b1, r_f};
                    o_en.bwd_we = 1'b1;
                    o_bwd_waddr = r_f[AW-1:0];
                    o_bwd_wdata = r_node;
                    n_state     = S_A3;
                end
            end
            S_A3: begin
                o_en.fwd_we = 1'b1;
                o_fwd_waddr = r_f[AW-1:0];
                o_fwd_wdata = {1'b1, r_nxt};
                if (rd_fwd != NIL) begin
                    o_en.bwd_we = 1'b1;
                    o_bwd_waddr = rd_fwd[AW-1:0];
                    o_bwd_wdata = NIL;
                end
                n_pool_head = rd_fwd;
                n_alloc     = r_f;
                n_state     = S_A4;
            end
            S_A4: begin
                if (r_nxt != NIL) begin
                    o_en.bwd_we = 1'b1;
                    o_bwd_waddr = r_nxt[AW-1:0];
                    o_bwd_wdata = r_f;
                end
                n_state = S_DONE;
            end
            S_D1: begin
                o_en.fwd_re = 1'b1;
                o_fwd_raddr = r_node[AW-1:0];
                o_en.bwd_re = 1'b1;
                o_bwd_raddr = r_node[AW-1:0];
                n_state     = S_D2;
            end
            S_D2: begin
                if (!rd_mark) begin
                    n_status = ST_BAD;
                    n_state  = S_DONE;
                end else begin
                    // Push the node onto the free list; the old free head is kept in r_f.
                    n_nxt       = rd_fwd;
                    n_prv       = rd_bwd;
                    o_en.fwd_we = 1'b1;
                    o_fwd_waddr = r_node[AW-1:0];
                    o_fwd_wdata = {1'b0, r_pool_head};
                    o_en.bwd_we = 1'b1;
                    o_bwd_waddr = r_node[AW-1:0];
                    o_bwd_wdata = NIL;
                    n_f         = r_pool_head;
                    n_pool_head = r_node;
                    if (rd_bwd == NIL) begin
                        n_used_head = rd_fwd;
                    end
                    n_state = S_D3;
                end
            end
            S_D3: begin
                if (r_prv != NIL) begin
                    o_en.fwd_we = 1'b1;
                    o_fwd_waddr = r_prv[AW-1:0];
                    o_fwd_wdata = {1'b1, r_nxt};
                end
                if (r_nxt != NIL) begin
                    o_en.bwd_we = 1'b1;
                    o_bwd_waddr = r_nxt[AW-1:0];
                    o_bwd_wdata = r_prv;
                end
                n_state = S_D4;
            end
            S_D4: begin
                if (r_f != NIL) begin
                    o_en.bwd_we = 1'b1;
                    o_bwd_waddr = r_f[AW-1:0];
                    o_bwd_wdata = r_node;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_cnt  <= '0;
            r_used_head <= NIL;
            r_pool_head <= '0;
        end else begin
            r_state     <= n_state;
            r_init_cnt  <= n_init_cnt;
            r_used_head <= n_used_head;
            r_pool_head <= n_pool_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node   <= n_node;
        r_f      <= n_f;
        r_nxt    <= n_nxt;
        r_prv    <= n_prv;
        r_alloc  <= n_alloc;
        r_status <= n_status;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_alloc     = r_alloc;
    assign o_status    = r_status;
    assign o_list_head = r_used_head;
    assign o_free_head = r_pool_head;

endmodule

@@ rtl/linked_list_free_pool_manager.sv @@
// Pool of NODES nodes kept on a doubly linked in-use list and a free list, with the links
// held in two single-port-write memories (forward link plus in-list mark, and backward
// link). After reset the block runs an initialization sweep that chains the free list
// 0..NODES-1; tready stays low until it ends. One command is worked at a time: insert
// at head and insert after on an empty list step through S_H1 to S_H3, other inserts
// after a node through S_A1 to S_A4, deletes through S_D1 to S_D4, and commands that end
// in an error leave for S_DONE early. A finished result sits in an output register, so
// the next command is accepted while the previous result waits to be taken. Node index
// NODES is the null node.
module linked_list_free_pool_manager
    import llfp_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // command, node (from the lowest bit up), zero padded to whole bytes
    input  logic [((($clog2(NODES+1)+2)+7)/8)*8-1:0] i_s_tdata,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // allocated_node, status, list_head, free_head (from the lowest bit up), zero padded
    output logic [(((3*$clog2(NODES+1)+2)+7)/8)*8-1:0] o_m_tdata
);

    localparam int NW    = $clog2(NODES + 1);
    localparam int AW    = $clog2(NODES);
    localparam int OUT_W = (((3 * NW + 2) + 7) / 8) * 8;

    t_mem_en       mem_en;
    logic [AW-1:0] fwd_raddr, fwd_waddr, bwd_raddr, bwd_waddr;
    logic [NW:0]   fwd_wdata, fwd_rdata;
    logic [NW-1:0] bwd_wdata, bwd_rdata;

    logic          res_valid, res_ready;
    logic [NW-1:0] res_alloc, res_list_head, res_free_head;
    logic [1:0]    res_status;

    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    llfp_ctrl #(
        .NODES(NODES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_cmd       (i_s_tdata[1:0]),
        .i_node      (i_s_tdata[2 +: NW]),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_alloc     (res_alloc),
        .o_status    (res_status),
        .o_list_head (res_list_head),
        .o_free_head (res_free_head),
        .o_en        (mem_en),
        .o_fwd_raddr (fwd_raddr),
        .o_fwd_waddr (fwd_waddr),
        .o_fwd_wdata (fwd_wdata),
        .i_fwd_rdata (fwd_rdata),
        .o_bwd_raddr (bwd_raddr),
        .o_bwd_waddr (bwd_waddr),
        .o_bwd_wdata (bwd_wdata),
        .i_bwd_rdata (bwd_rdata)
    );

    llfp_link_mem #(
        .NODES(NODES)
    ) u_mem (
        .i_clk       (i_clk),
        .i_en        (mem_en),
        .i_fwd_raddr (fwd_raddr),
        .i_fwd_waddr (fwd_waddr),
        .i_fwd_wdata (fwd_wdata),
        .o_fwd_rdata (fwd_rdata),
        .i_bwd_raddr (bwd_raddr),
        .i_bwd_waddr (bwd_waddr),
        .i_bwd_wdata (bwd_wdata),
        .o_bwd_rdata (bwd_rdata)
    );

    // The output register takes a new result when it is empty or being emptied.
    assign res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out_data <= OUT_W'({res_free_head, res_list_head, res_status, res_alloc});
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

@@ rtl/llfp_checker.sv @@
`include "linked_list_free_pool_manager_defines.svh"

module llfp_checker
    import llfp_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_m_tvalid,
    input logic i_m_tready,
    input logic [(((3*$clog2(NODES+1)+2)+7)/8)*8-1:0] i_m_tdata
);

    localparam int NW = $clog2(NODES + 1);
    localparam logic [NW-1:0] NIL = NW'(NODES);

    logic [NW-1:0] alloc, list_head, free_head;
    logic [1:0]    status;
    logic          has_alloc;
    logic          out_empty;
    logic          alloc_linked;

    assign alloc     = i_m_tdata[NW-1:0];
    assign status    = i_m_tdata[NW +: 2];
    assign list_head = i_m_tdata[NW+2 +: NW];
    assign free_head = i_m_tdata[2*NW+2 +: NW];

    assign has_alloc    = i_m_tvalid && (alloc != NIL);
    assign out_empty    = i_m_tvalid && (status == ST_EMPTY);
    assign alloc_linked = (free_head != alloc) && (list_head != NIL);

    `LLFP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid)
    `LLFP_ASSERT_NOW(a_alloc_ok, i_clk, i_rst_n, has_alloc, status == ST_OK)
    `LLFP_ASSERT_NOW(a_empty_pool, i_clk, i_rst_n, out_empty, free_head == NIL)
    `LLFP_ASSERT_NOW(a_alloc_used, i_clk, i_rst_n, has_alloc, alloc_linked)

endmodule

bind linked_list_free_pool_manager llfp_checker #(
    .NODES(NODES)
) u_llfp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);
